@@ rtl/core/led_animation_sequencer_core_macros.svh @@
// Assertion helpers for the LED animation sequencer core.
`ifndef LED_ANIMATION_SEQUENCER_CORE_MACROS_SVH
`define LED_ANIMATION_SEQUENCER_CORE_MACROS_SVH

// Condition that must hold at every edge outside reset.
`define LASC_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("lasc: invariant violated");

// Condition that must hold in the cycle after the trigger.
`define LASC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lasc: follow-up check failed");

`endif

@@ rtl/core/lasc_pkg.sv @@
`timescale 1ns / 1ps

package lasc_pkg;

  localparam int PERIOD_W   = 16;
  localparam int ROUND_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int LED_OUT_W  = 8;
  localparam int PHASE_W    = 2;

  typedef logic [PERIOD_W-1:0]   period_t;
  typedef logic [ROUND_W-1:0]    round_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [LED_OUT_W-1:0]  led_out_t;
  typedef logic [PHASE_W-1:0]    phase_t;

  // Register indexes
  localparam cfg_idx_t REG_STEP_PERIOD  = 3'd0;
  localparam cfg_idx_t REG_BLINK_PERIOD = 3'd1;
  localparam cfg_idx_t REG_PINGPONG_RND = 3'd2;
  localparam cfg_idx_t REG_INOUT_RND    = 3'd3;
  localparam cfg_idx_t REG_BLINK_RND    = 3'd4;

  // Reset values of the registers
  localparam period_t RST_STEP_PERIOD  = 16'd200;
  localparam period_t RST_BLINK_PERIOD = 16'd500;
  localparam round_t  RST_ROUNDS       = 8'd4;

  // Phase codes
  localparam phase_t PHASE_PINGPONG = 2'd0;
  localparam phase_t PHASE_INOUT    = 2'd1;
  localparam phase_t PHASE_BLINK    = 2'd2;

  typedef struct packed {
    period_t step_period;
    period_t blink_period;
    round_t  pingpong_rounds;
    round_t  inout_rounds;
    round_t  blink_rounds;
  } cfg_t;

endpackage

@@ rtl/core/lasc_if.sv @@
`timescale 1ns / 1ps

// Tick channel: each transaction carries at most one timer tick.
interface lasc_tick_if
  import lasc_pkg::*;
  ();
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

// LED channel: mask and phase after each tick transaction.
interface lasc_led_if
  import lasc_pkg::*;
  ();
  logic     valid;
  logic     ready;
  led_out_t led_mask;
  phase_t   phase;

  modport source (output valid, output led_mask, output phase, input ready);
  modport sink   (input valid, input led_mask, input phase, output ready);
endinterface

@@ rtl/core/led_animation_sequencer_core.sv @@
// Channel   | Dir | Payload                | Notes
// ----------+-----+------------------------+----------------------------------
// tick_ch   | in  | tick (1)               | one transaction per timer tick
// led_ch    | out | led_mask (8), phase(2) | one transaction per tick taken
// cfg       | in  | cfg_index(3), data(16) | write-only, taken when cfg_we high
//
// One tick transaction is taken per clock while tick_ch.ready is high; its
// result is in the output register on the next cycle.
// The whole show step (prescalers, sweeps, blink) is one combinational pass
// between the animation state and the output register.
// tick_ch.ready drops only while a result sits unread and led_ch is stalled.
// rst is synchronous: state registers return to defaults, LEDs off, phase 0.
`timescale 1ns / 1ps

`include "led_animation_sequencer_core_macros.svh"

module led_animation_sequencer_core
  import lasc_pkg::*;
#(
  parameter int LED_COUNT = 8
) (
  input  logic             clk,
  input  logic             rst,
  lasc_tick_if.sink        tick_ch,
  lasc_led_if.source       led_ch,
  input  logic             cfg_we,
  input  cfg_idx_t         cfg_index,
  input  cfg_data_t        cfg_data
);

  // Widths that follow from the LED count
  localparam int POS_W  = $clog2(LED_COUNT);
  localparam int OFF_W  = $clog2(LED_COUNT / 2);
  localparam int MASK_W = (LED_COUNT > LED_OUT_W) ? LED_COUNT : LED_OUT_W;

  localparam logic [POS_W-1:0]  LAST_POS = POS_W'(LED_COUNT - 1);
  localparam logic [POS_W-1:0]  MID_POS  = POS_W'(LED_COUNT / 2 - 1);
  localparam logic [OFF_W-1:0]  MID_OFF  = OFF_W'(LED_COUNT / 2 - 1);
  localparam logic [MASK_W-1:0] ONE_LED  = MASK_W'(1);
  localparam logic [MASK_W-1:0] ALL_LEDS = {MASK_W{1'b1}} >> (MASK_W - LED_COUNT);

  // Configuration registers
  cfg_t cfg;

  // Animation state
  period_t           step_prescale, step_prescale_next;
  period_t           blink_prescale, blink_prescale_next;
  logic [POS_W-1:0]  sweep_position, sweep_position_next;
  logic              sweep_backward, sweep_backward_next;
  round_t            sweep_round_count, sweep_round_count_next;
  logic [OFF_W-1:0]  pair_offset, pair_offset_next;
  logic              pair_backward, pair_backward_next;
  round_t            pair_round_count, pair_round_count_next;
  logic              blink_lit, blink_lit_next;
  round_t            blink_round_count, blink_round_count_next;
  logic              inout_active, inout_active_next;
  logic              blink_active, blink_active_next;
  logic [MASK_W-1:0] mask_register, mask_register_next;

  // Output register
  logic     out_valid;
  led_out_t led_mask_q;
  phase_t   phase_q;

  logic              tick_acc;
  period_t           step_inc, blink_inc;
  logic              step_fire, blink_fire;
  logic [POS_W-1:0]  pos_dec;
  logic [POS_W-1:0]  pos_inc;
  logic [OFF_W-1:0]  off_dec;
  logic [OFF_W-1:0]  off_inc;
  logic [MASK_W-1:0] single_mask, pair_mask;
  phase_t            phase_next;

  // Handshake: output register frees up when empty or being drained
  assign tick_ch.ready   = !out_valid || led_ch.ready;
  assign tick_acc        = tick_ch.valid && tick_ch.ready;
  assign led_ch.valid    = out_valid;
  assign led_ch.led_mask = led_mask_q;
  assign led_ch.phase    = phase_q;

  // Prescalers fire on equality after the increment (wrap at 2^16)
  assign step_inc   = step_prescale + 1'b1;
  assign blink_inc  = blink_prescale + 1'b1;
  assign step_fire  = (step_inc == cfg.step_period);
  assign blink_fire = (blink_inc == cfg.blink_period);

  assign pos_inc = sweep_position + 1'b1;
  assign pos_dec = (sweep_position != '0) ? sweep_position - 1'b1 : sweep_position;
  assign off_inc = pair_offset + 1'b1;
  assign off_dec = (pair_offset != '0) ? pair_offset - 1'b1 : pair_offset;

  // Masks are built from the position held before this step moves it
  assign single_mask = ONE_LED << sweep_position;
  assign pair_mask   = (ONE_LED << (MID_POS - POS_W'(pair_offset)))
                     | (ONE_LED << (MID_POS + POS_W'(pair_offset) + 1'b1));

  always_comb begin
    step_prescale_next     = step_prescale;
    blink_prescale_next    = blink_prescale;
    sweep_position_next    = sweep_position;
    sweep_backward_next    = sweep_backward;
    sweep_round_count_next = sweep_round_count;
    pair_offset_next       = pair_offset;
    pair_backward_next     = pair_backward;
    pair_round_count_next  = pair_round_count;
    blink_lit_next         = blink_lit;
    blink_round_count_next = blink_round_count;
    inout_active_next      = inout_active;
    blink_active_next      = blink_active;
    mask_register_next     = mask_register;

    if (tick_ch.tick) begin
      step_prescale_next  = step_fire ? '0 : step_inc;
      blink_prescale_next = blink_fire ? '0 : blink_inc;

      // Step task: ping-pong first, in-out may follow in the same tick
      if (step_fire && !blink_active) begin
        if (!inout_active) begin
          mask_register_next = single_mask;
          if (sweep_round_count >= cfg.pingpong_rounds) begin
            inout_active_next = 1'b1;
          end else if (!sweep_backward) begin
            sweep_position_next = pos_inc;
            if (pos_inc >= LAST_POS) begin
              sweep_backward_next = 1'b1;
            end
          end else begin
            sweep_position_next = pos_dec;
            if (pos_dec == '0) begin
              sweep_backward_next    = 1'b0;
              sweep_round_count_next = sweep_round_count + 1'b1;
            end
          end
        end
        if (inout_active_next) begin
          mask_register_next = pair_mask;
          if (pair_round_count >= cfg.inout_rounds) begin
            blink_active_next = 1'b1;
          end else if (!pair_backward) begin
            pair_offset_next = off_inc;
            if (off_inc >= MID_OFF) begin
              pair_backward_next = 1'b1;
            end
          end else begin
            pair_offset_next = off_dec;
            if (off_dec == '0) begin
              pair_backward_next    = 1'b0;
              pair_round_count_next = pair_round_count + 1'b1;
            end
          end
        end
      end

      // Blink task sees a blink phase entered earlier in this tick
      if (blink_fire && blink_active_next) begin
        if (blink_round_count >= cfg.blink_rounds) begin
          // Show restarts; mask and positions are kept
          inout_active_next      = 1'b0;
          blink_active_next      = 1'b0;
          sweep_round_count_next = '0;
          pair_round_count_next  = '0;
          blink_round_count_next = '0;
        end else if (!blink_lit) begin
          mask_register_next = ALL_LEDS;
          blink_lit_next     = 1'b1;
        end else begin
          mask_register_next     = '0;
          blink_lit_next         = 1'b0;
          blink_round_count_next = blink_round_count + 1'b1;
        end
      end
    end

    if (blink_active_next) begin
      phase_next = PHASE_BLINK;
    end else if (inout_active_next) begin
      phase_next = PHASE_INOUT;
    end else begin
      phase_next = PHASE_PINGPONG;
    end
  end

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_period     <= RST_STEP_PERIOD;
      cfg.blink_period    <= RST_BLINK_PERIOD;
      cfg.pingpong_rounds <= RST_ROUNDS;
      cfg.inout_rounds    <= RST_ROUNDS;
      cfg.blink_rounds    <= RST_ROUNDS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP_PERIOD:  cfg.step_period     <= cfg_data[PERIOD_W-1:0];
        REG_BLINK_PERIOD: cfg.blink_period    <= cfg_data[PERIOD_W-1:0];
        REG_PINGPONG_RND: cfg.pingpong_rounds <= cfg_data[ROUND_W-1:0];
        REG_INOUT_RND:    cfg.inout_rounds    <= cfg_data[ROUND_W-1:0];
        REG_BLINK_RND:    cfg.blink_rounds    <= cfg_data[ROUND_W-1:0];
        default: ;
      endcase
    end
  end

  // State advances only on an accepted tick transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      step_prescale     <= '0;
      blink_prescale    <= '0;
      sweep_position    <= '0;
      sweep_backward    <= 1'b0;
      sweep_round_count <= '0;
      pair_offset       <= '0;
      pair_backward     <= 1'b0;
      pair_round_count  <= '0;
      blink_lit         <= 1'b0;
      blink_round_count <= '0;
      inout_active      <= 1'b0;
      blink_active      <= 1'b0;
      mask_register     <= '0;
    end else if (tick_acc) begin
      step_prescale     <= step_prescale_next;
      blink_prescale    <= blink_prescale_next;
      sweep_position    <= sweep_position_next;
      sweep_backward    <= sweep_backward_next;
      sweep_round_count <= sweep_round_count_next;
      pair_offset       <= pair_offset_next;
      pair_backward     <= pair_backward_next;
      pair_round_count  <= pair_round_count_next;
      blink_lit         <= blink_lit_next;
      blink_round_count <= blink_round_count_next;
      inout_active      <= inout_active_next;
      blink_active      <= blink_active_next;
      mask_register     <= mask_register_next;
    end
  end

  // Output register: loads on accept, clears when drained with nothing new
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick_acc) begin
      out_valid <= 1'b1;
    end else if (led_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      led_mask_q <= mask_register_next[LED_OUT_W-1:0];
      phase_q    <= phase_next;
    end
  end

  // Checks
  `LASC_ASSERT_ALWAYS(a_blink_within_inout, clk, rst, !blink_active || inout_active)
  `LASC_ASSERT_ALWAYS(a_sweep_pos_range, clk, rst, sweep_position <= LAST_POS)
  `LASC_ASSERT_ALWAYS(a_pair_off_range, clk, rst, pair_offset <= MID_OFF)
  `LASC_ASSERT_NEXT(a_accept_loads_result, clk, rst, tick_acc, out_valid)

endmodule

@@ test/lasc_show_monitor.sv @@
`timescale 1ns / 1ps

// Watches both channels and the register port. It keeps its own copy of the
// show state and checks every LED transaction against it.
module lasc_show_monitor
  import lasc_pkg::*;
#(
  parameter int LED_COUNT = 8
) (
  input  logic       clk,
  input  logic       rst,
  lasc_tick_if       tick_mon,
  lasc_led_if        led_mon,
  input  logic       cfg_we,
  input  cfg_idx_t   cfg_index,
  input  cfg_data_t  cfg_data,
  output int         fails,
  output int         pending,
  output int         checked,
  output logic [2:0] phases_seen
);

  localparam int POS_W = $clog2(LED_COUNT);
  localparam int MID   = LED_COUNT / 2 - 1;

  typedef struct packed {
    led_out_t led_mask;
    phase_t   phase;
  } led_result_t;

  cfg_t                 show_cfg;
  period_t              step_cnt;
  period_t              blink_cnt;
  logic [POS_W-1:0]     sweep_pos;
  logic [POS_W-1:0]     pair_off;
  logic                 sweep_back;
  logic                 pair_back;
  logic                 blink_lit;
  logic                 inout_on;
  logic                 blink_on;
  round_t               sweep_rnds;
  round_t               pair_rnds;
  round_t               blink_rnds;
  logic [LED_COUNT-1:0] show_mask;

  led_result_t expected_leds_q[$];
  led_result_t want;
  led_result_t got;

  task automatic reset_show();
    show_cfg.step_period     = RST_STEP_PERIOD;
    show_cfg.blink_period    = RST_BLINK_PERIOD;
    show_cfg.pingpong_rounds = RST_ROUNDS;
    show_cfg.inout_rounds    = RST_ROUNDS;
    show_cfg.blink_rounds    = RST_ROUNDS;
    step_cnt   = '0;
    blink_cnt  = '0;
    sweep_pos  = '0;
    sweep_back = 1'b0;
    sweep_rnds = '0;
    pair_off   = '0;
    pair_back  = 1'b0;
    pair_rnds  = '0;
    blink_lit  = 1'b0;
    blink_rnds = '0;
    inout_on   = 1'b0;
    blink_on   = 1'b0;
    show_mask  = '0;
  endtask

  // Single LED sweep; returns 1 once its rounds are used up.
  function automatic logic sweep_step();
    show_mask            = '0;
    show_mask[sweep_pos] = 1'b1;
    if (sweep_rnds >= show_cfg.pingpong_rounds) return 1'b1;
    if (!sweep_back) begin
      sweep_pos = sweep_pos + 1'b1;
      if (sweep_pos >= LED_COUNT - 1) sweep_back = 1'b1;
    end else begin
      if (sweep_pos > 0) sweep_pos = sweep_pos - 1'b1;
      if (sweep_pos == 0) begin
        sweep_back = 1'b0;
        sweep_rnds = sweep_rnds + 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Pair around the middle; returns 1 once its rounds are used up.
  function automatic logic pair_step();
    show_mask                            = '0;
    show_mask[POS_W'(MID - pair_off)]     = 1'b1;
    show_mask[POS_W'(MID + pair_off + 1)] = 1'b1;
    if (pair_rnds >= show_cfg.inout_rounds) return 1'b1;
    if (!pair_back) begin
      pair_off = pair_off + 1'b1;
      if (pair_off >= MID) pair_back = 1'b1;
    end else begin
      if (pair_off > 0) pair_off = pair_off - 1'b1;
      if (pair_off == 0) begin
        pair_back = 1'b0;
        pair_rnds = pair_rnds + 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void blink_step();
    if (blink_rnds >= show_cfg.blink_rounds) begin
      // restart: flags and round counts clear, mask and positions stay
      inout_on   = 1'b0;
      blink_on   = 1'b0;
      sweep_rnds = '0;
      pair_rnds  = '0;
      blink_rnds = '0;
    end else if (!blink_lit) begin
      show_mask = '1;
      blink_lit = 1'b1;
    end else begin
      show_mask  = '0;
      blink_lit  = 1'b0;
      blink_rnds = blink_rnds + 1'b1;
    end
  endfunction

  // One tick transaction: step task first, then blink task.
  function automatic led_result_t advance_show(input logic tick);
    led_result_t r;
    if (tick) begin
      step_cnt = step_cnt + 1'b1;
      if (step_cnt == show_cfg.step_period) begin
        step_cnt = '0;
        if (!blink_on) begin
          if (!inout_on) begin
            if (sweep_step()) inout_on = 1'b1;
          end
          if (inout_on) begin
            if (pair_step()) blink_on = 1'b1;
          end
        end
      end
      blink_cnt = blink_cnt + 1'b1;
      if (blink_cnt == show_cfg.blink_period) begin
        blink_cnt = '0;
        if (blink_on) blink_step();
      end
    end
    r.led_mask = led_out_t'(show_mask);
    r.phase    = blink_on ? PHASE_BLINK : (inout_on ? PHASE_INOUT : PHASE_PINGPONG);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      reset_show();
      expected_leds_q.delete();
      fails       = 0;
      checked     = 0;
      phases_seen = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_STEP_PERIOD:  show_cfg.step_period     = cfg_data;
          REG_BLINK_PERIOD: show_cfg.blink_period    = cfg_data;
          REG_PINGPONG_RND: show_cfg.pingpong_rounds = round_t'(cfg_data);
          REG_INOUT_RND:    show_cfg.inout_rounds    = round_t'(cfg_data);
          REG_BLINK_RND:    show_cfg.blink_rounds    = round_t'(cfg_data);
          default: ;
        endcase
      end
      if (tick_mon.valid && tick_mon.ready)
        expected_leds_q.push_back(advance_show(tick_mon.tick));
      if (led_mon.valid && led_mon.ready) begin
        got.led_mask = led_mon.led_mask;
        got.phase    = led_mon.phase;
        if (expected_leds_q.size() == 0) begin
          $display("%0t: LED transaction with no tick waiting: mask %h phase %0d",
                   $time, got.led_mask, got.phase);
          fails++;
        end else begin
          want = expected_leds_q.pop_front();
          checked++;
          if (got.led_mask !== want.led_mask) begin
            $display("%0t: led_mask expected %h, got %h", $time, want.led_mask, got.led_mask);
            fails++;
          end
          if (got.phase !== want.phase) begin
            $display("%0t: phase expected %0d, got %0d", $time, want.phase, got.phase);
            fails++;
          end
          case (want.phase)
            PHASE_PINGPONG: phases_seen[0] = 1'b1;
            PHASE_INOUT:    phases_seen[1] = 1'b1;
            PHASE_BLINK:    phases_seen[2] = 1'b1;
            default: ;
          endcase
        end
      end
    end
    pending <= expected_leds_q.size();
  end

endmodule

@@ test/led_animation_sequencer_core_tb.sv @@
`timescale 1ns / 1ps

// Top of the bench: makes clock, reset, tick transactions, register writes
// and receiver back-pressure. Prediction and checking sit in the monitor.
module led_animation_sequencer_core_tb;
  import lasc_pkg::*;

  localparam int IDLE_LIMIT   = 1000;  // cycles without any transaction
  localparam int RANDOM_ITEMS = 400;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_data;

  lasc_tick_if tick_ch();
  lasc_led_if  led_ch();

  int         mon_fails;
  int         mon_pending;
  int         mon_checked;
  logic [2:0] phases_seen;

  // Sender burst state and tally
  int burst_left   = 0;
  int items_sent   = 0;
  int ticks_sent   = 0;
  int settings_run = 0;

  // Running prescaler counts as seen from the sender, so that new periods
  // can be chosen above them (otherwise the counters run the long way round)
  period_t step_seen = '0;
  period_t blink_seen = '0;
  period_t step_per = RST_STEP_PERIOD;
  period_t blink_per = RST_BLINK_PERIOD;

  // Receiver stall pattern
  int          stall_cyc  = 0;
  int          stall_mode = 0;
  logic [15:0] stall_bits = 16'hFFFF;

  int idle_cycles = 0;

  always #10 clk = ~clk;

  led_animation_sequencer_core u_top (
    .clk      (clk),
    .rst      (rst),
    .tick_ch  (tick_ch),
    .led_ch   (led_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  lasc_show_monitor u_show_mon (
    .clk        (clk),
    .rst        (rst),
    .tick_mon   (tick_ch),
    .led_mon    (led_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fails      (mon_fails),
    .pending    (mon_pending),
    .checked    (mon_checked),
    .phases_seen(phases_seen)
  );

  // Receiver: changes its manner on a free-running cycle counter. Mode 0 never
  // stalls; the pattern mode repeats a 16-bit pattern with bits 0 and 8 set.
  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 1;
    if (stall_cyc % 128 == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_bits <= 16'($urandom) | 16'h0101;
    end
    case (stall_mode)
      0:       led_ch.ready <= 1'b1;
      1:       led_ch.ready <= ($urandom_range(0, 3) != 0);
      2:       led_ch.ready <= stall_bits[4'(stall_cyc % 16)];
      default: led_ch.ready <= ($urandom_range(0, 1) != 0);
    endcase
  end

  // Watchdog: any transaction on either channel restarts the count
  always @(posedge clk) begin
    if (rst || (tick_ch.valid && tick_ch.ready) || (led_ch.valid && led_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("led_animation_sequencer_core_tb NOT OK");
      $finish;
    end
  end

  function automatic cfg_t show_settings(input period_t step_p, input period_t blink_p,
                                         input round_t pp, input round_t io, input round_t bl);
    cfg_t c;
    c.step_period     = step_p;
    c.blink_period    = blink_p;
    c.pingpong_rounds = pp;
    c.inout_rounds    = io;
    c.blink_rounds    = bl;
    return c;
  endfunction

  // One tick transaction. At the start of a burst the sender may first drop
  // valid and sit idle; valid stays high across back-to-back transactions.
  task automatic send_tick(input logic t);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        tick_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.tick  <= t;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    burst_left--;
    items_sent++;
    if (t) begin
      ticks_sent++;
      step_seen  = step_seen + 1'b1;
      blink_seen = blink_seen + 1'b1;
      if (step_seen == step_per) step_seen = '0;
      if (blink_seen == blink_per) blink_seen = '0;
    end
  endtask

  // all_ticks = 0: roughly one transaction in five carries no tick
  task automatic send_ticks(input int n, input bit all_ticks);
    for (int i = 0; i < n; i++)
      send_tick(all_ticks ? 1'b1 : ($urandom_range(0, 4) != 0));
  endtask

  // Stop sending and wait for every expected LED transaction
  task automatic drain();
    tick_ch.valid <= 1'b0;
    @(posedge clk);
    while (mon_pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // New settings, written only with the block idle. Unless a wrap is wanted,
  // extra ticks first bring both counts below the new periods.
  task automatic apply_settings(input cfg_t c, input bit allow_wrap);
    if (!allow_wrap)
      while (step_seen >= c.step_period || blink_seen >= c.blink_period) send_tick(1'b1);
    drain();
    write_reg(REG_STEP_PERIOD, c.step_period);
    write_reg(REG_BLINK_PERIOD, c.blink_period);
    write_reg(REG_PINGPONG_RND, cfg_data_t'(c.pingpong_rounds));
    write_reg(REG_INOUT_RND, cfg_data_t'(c.inout_rounds));
    write_reg(REG_BLINK_RND, cfg_data_t'(c.blink_rounds));
    cfg_we <= 1'b0;
    step_per  = c.step_period;
    blink_per = c.blink_period;
    settings_run++;
  endtask

  initial begin
    int random_items;
    int n;
    round_t pp;
    round_t io;
    round_t bl;
    random_items  = 0;
    tick_ch.valid = 1'b0;
    tick_ch.tick  = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_STEP_PERIOD;
    cfg_data      = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Out of reset with default settings: empty transactions leave the
    // show alone, LEDs off, phase ping-pong
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    // Default step period fires twice here; blink fires but is not active
    send_ticks(505, 1'b1);

    // Both periods dropped below the running counts: the prescalers have to
    // wrap through 65535 before the show moves again, then one-round show
    apply_settings(show_settings(16'd1, 16'd3, 8'd1, 8'd1, 8'd1), 1'b1);
    send_ticks(65700, 1'b1);

    // Zero rounds everywhere: ping-pong hands to in-out, in-out to blink,
    // and blink restarts, all within one tick with the mask kept
    apply_settings(show_settings(16'd1, 16'd1, 8'd0, 8'd0, 8'd0), 1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b1);

    // Step and blink firing on the same tick
    apply_settings(show_settings(16'd2, 16'd1, 8'd1, 8'd1, 8'd2), 1'b0);
    send_ticks(60, 1'b0);

    // Random settings, short periods and few rounds so that every phase of
    // the show comes round; state carries over between settings
    while (random_items < RANDOM_ITEMS) begin
      pp = round_t'(($urandom_range(0, 5) == 0) ? $urandom_range(2, 5) : $urandom_range(0, 1));
      io = round_t'(($urandom_range(0, 5) == 0) ? $urandom_range(2, 5) : $urandom_range(0, 1));
      bl = round_t'(($urandom_range(0, 5) == 0) ? $urandom_range(3, 6) : $urandom_range(0, 2));
      apply_settings(show_settings(period_t'($urandom_range(1, 4)),
                                   period_t'($urandom_range(1, 8)), pp, io, bl),
                     1'b0);
      n = $urandom_range(30, 80);
      send_ticks(n, 1'b0);
      random_items += n;
    end

    // Widest settings: every bit of each register set
    apply_settings(show_settings(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF), 1'b0);
    send_ticks(40, 1'b0);

    drain();
    repeat (3) @(posedge clk);

    $display("run: %0d tick transactions (%0d carrying a tick) over %0d settings,",
             items_sent, ticks_sent, settings_run);
    $display("run: %0d LED results checked; phases reached ping-pong %0b, in-out %0b, blink %0b",
             mon_checked, phases_seen[0], phases_seen[1], phases_seen[2]);
    if (mon_fails == 0)
      $display("led_animation_sequencer_core_tb OK");
    else
      $display("led_animation_sequencer_core_tb NOT OK");
    $finish;
  end

endmodule
